// ===== design/gcs_pkg.sv =====
// shared types and constants for the g-code comment stripper
package gcs_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned RES_DEPTH  = 4;
  localparam int unsigned RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

  localparam logic [BYTE_W-1:0] NEWLINE_CODE       = 8'h0A;
  localparam logic [BYTE_W-1:0] MERGE_LIMIT_RESET  = 8'd250;
  localparam logic [BYTE_W-1:0] COMMENT_CHAR_RESET = 8'd59;
  localparam logic [BYTE_W-1:0] MERGED_MAX         = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_CHAR = 1'd1;

  // filter mode codes
  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_HELD    = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              end_of_stream;
    logic              last_of_run;
  } res_t;

  // what one step hands to the result queue and the state registers
  typedef struct packed {
    logic [1:0]        push_cnt;
    res_t              res0;
    res_t              res1;
    mode_t             mode_nxt;
    logic [BYTE_W-1:0] merged_nxt;
  } step_out_t;

endpackage

// ===== design/gcode_comment_stripper.sv =====
// top level of the g-code comment stripper
//
// Usage:
//   Input channel (in_valid/in_ready) takes one text byte per beat, with
//   in_last_byte marking the final byte of a stream. Comment text, from the
//   comment character to the newline, is dropped; consecutive comment lines
//   collapse into one newline, up to merge_limit merged lines.
//   Output channel (out_valid/out_ready) sends one result beat per cycle
//   while ready: a byte, a validity flag, an end-of-stream flag and a
//   last-of-run flag. An input byte yields zero, one or two result beats.
//   Config channel (cfg_valid/cfg_ready, always ready) writes merge_limit
//   (index 0) or comment_char (index 1); write only while the block is idle.
// Timing:
//   A byte is held in an input register, filtered combinationally and
//   written into a four-entry result queue, whose head drives the outputs.
//   One byte is taken per cycle while the queue has room for two beats;
//   the queue's single read port sets the output at one beat per cycle
//   while the receiver is ready, so bytes that release two beats fill it.
// Reset: filter state, queue and config registers return to defaults
//   (merge_limit 250, comment_char ';'). A receiver stall fills the queue,
//   then in_ready drops; nothing is lost.
module gcode_comment_stripper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gcs_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gcs_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_byte_valid,
  output logic                               out_end_of_stream,
  output logic                               out_last_of_run,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcs_pkg::BYTE_W-1:0]         cfg_data
);
  import gcs_pkg::*;

  logic [BYTE_W-1:0] merge_limit_r;
  logic [BYTE_W-1:0] comment_char_r;
  mode_t             mode_r;
  logic [BYTE_W-1:0] merged_r;
  logic              stg_vld_r;
  logic [BYTE_W-1:0] stg_byte_r;
  logic              stg_last_r;
  logic              adv;
  logic              has_room2;
  step_out_t         step;
  res_t              head;
  logic [1:0]        push_cnt;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_limit_r  <= MERGE_LIMIT_RESET;
      comment_char_r <= COMMENT_CHAR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MERGE_LIMIT:  merge_limit_r  <= cfg_data;
        CFG_COMMENT_CHAR: comment_char_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register advances when the queue can take two beats
  assign adv      = stg_vld_r && has_room2;
  assign in_ready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_data_byte;
      stg_last_r <= in_last_byte;
    end
  end

  // filter step
  gcs_step u_step (
    .mode         (mode_r),
    .merged       (merged_r),
    .data_byte    (stg_byte_r),
    .last_byte    (stg_last_r),
    .merge_limit  (merge_limit_r),
    .comment_char (comment_char_r),
    .step         (step)
  );

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_TEXT;
      merged_r <= '0;
    end else if (adv) begin
      mode_r   <= step.mode_nxt;
      merged_r <= step.merged_nxt;
    end
  end

  assign push_cnt = adv ? step.push_cnt : 2'd0;

  // result queue
  gcs_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (step.res0),
    .push1     (step.res1),
    .has_room2 (has_room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte          = head.data;
  assign out_byte_valid    = head.byte_valid;
  assign out_end_of_stream = head.end_of_stream;
  assign out_last_of_run   = head.last_of_run;

endmodule

// ===== design/gcs_step.sv =====
// combinational filter step: one byte in, up to two result beats out
module gcs_step (
  input  gcs_pkg::mode_t                 mode,
  input  logic [gcs_pkg::BYTE_W-1:0]     merged,
  input  logic [gcs_pkg::BYTE_W-1:0]     data_byte,
  input  logic                           last_byte,
  input  logic [gcs_pkg::BYTE_W-1:0]     merge_limit,
  input  logic [gcs_pkg::BYTE_W-1:0]     comment_char,
  output gcs_pkg::step_out_t             step
);
  import gcs_pkg::*;

  always_comb begin
    logic [1:0]        n;
    res_t              r0;
    res_t              r1;
    mode_t             m;
    logic [BYTE_W-1:0] cnt;
    logic              emit_nl;
    logic              emit_c;
    logic              emit_tail;

    r0        = '0;
    r1        = '0;
    m         = mode;
    cnt       = merged;
    emit_nl   = 1'b0;
    emit_c    = 1'b0;
    emit_tail = 1'b0;

    // mode transition and the bytes it releases
    case (mode)
      MODE_COMMENT: begin
        if (data_byte == NEWLINE_CODE) begin
          if (merged >= merge_limit) begin
            emit_nl = 1'b1;
            cnt     = '0;
            m       = MODE_TEXT;
          end else begin
            m = MODE_HELD;
          end
        end
      end
      MODE_HELD: begin
        if (data_byte == comment_char) begin
          if (merged != MERGED_MAX) begin
            cnt = merged + 1'b1;
          end
          m = MODE_COMMENT;
        end else begin
          emit_nl = 1'b1;
          emit_c  = 1'b1;
          cnt     = '0;
          m       = MODE_TEXT;
        end
      end
      default: begin
        if (data_byte == comment_char) begin
          cnt = '0;
          m   = MODE_COMMENT;
        end else begin
          emit_c = 1'b1;
          m      = MODE_TEXT;
        end
      end
    endcase

    // first slot: held newline goes ahead of the byte
    if (emit_nl) begin
      r0.data       = NEWLINE_CODE;
      r0.byte_valid = 1'b1;
      if (emit_c) begin
        r1.data       = data_byte;
        r1.byte_valid = 1'b1;
        n             = 2'd2;
      end else begin
        n = 2'd1;
      end
    end else if (emit_c) begin
      r0.data       = data_byte;
      r0.byte_valid = 1'b1;
      n             = 2'd1;
    end else begin
      n = 2'd0;
    end

    // end of stream: flush a pending newline, else mark the last beat or send a bare end mark
    if (last_byte) begin
      emit_tail = (m == MODE_HELD) || ((m == MODE_COMMENT) && (cnt != '0));
      if (emit_tail) begin
        if (n == 2'd0) begin
          r0.data       = NEWLINE_CODE;
          r0.byte_valid = 1'b1;
        end else begin
          r1.data       = NEWLINE_CODE;
          r1.byte_valid = 1'b1;
        end
        n = n + 2'd1;
      end else if (n == 2'd0) begin
        n = 2'd1;
      end
      if (n == 2'd2) begin
        r1.end_of_stream = 1'b1;
      end else begin
        r0.end_of_stream = 1'b1;
      end
      m   = MODE_TEXT;
      cnt = '0;
    end

    // mark the final beat of this input
    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end

    step.push_cnt   = n;
    step.res0       = r0;
    step.res1       = r1;
    step.mode_nxt   = m;
    step.merged_nxt = cnt;
  end

endmodule

// ===== design/gcs_res_fifo.sv =====
// result queue: takes up to two beats per cycle, sends one per cycle while the receiver is ready
module gcs_res_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     push_cnt,
  input  gcs_pkg::res_t                  push0,
  input  gcs_pkg::res_t                  push1,
  output logic                           has_room2,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gcs_pkg::res_t                  head
);
  import gcs_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r;
  logic [RES_PTR_W-1:0] wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r;
  logic [RES_PTR_W-1:0] rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r;
  logic [RES_CNT_W-1:0] count_nxt;
  logic                 pop;

  // room check uses the stored count only
  assign has_room2 = count_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + RES_PTR_W'(1)] <= push1;
    end
  end

endmodule

// ===== design/gcs_checker.sv =====
// port-level checks for the g-code comment stripper, bound to the top level
module gcs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gcs_pkg::BYTE_W-1:0]    out_byte,
  input logic                          out_byte_valid,
  input logic                          out_end_of_stream,
  input logic                          out_last_of_run
);

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_end_of_stream)
      && $stable(out_last_of_run) && $stable(out_byte_valid))
    else $error("output beat changed while stalled");

  // a bare end mark closes the stream and its run, with a zero byte
  a_bare_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_stream && out_last_of_run
      && (out_byte == '0))
    else $error("bare end mark malformed");

  // end of stream is always the last beat of its input
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_stream |-> out_last_of_run)
    else $error("end of stream without last of run");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gcode_comment_stripper gcs_checker u_gcs_checker (.*);
